// ----- src/sos_pkg.sv -----
// ----------------------------------------------------------------------------
// sos_pkg
// Shared constants, codes and control types for the set-of-stacks block.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_STACKS  = 8;

    localparam int STK_W   = $clog2(NUM_STACKS);
    localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ENTRIES = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    localparam int OP_W    = 2;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 3;
    localparam int ST_W    = 2;
    localparam int CUR_W   = 3;

    localparam int IN_BITS  = OP_W + VAL_W + IDX_W;
    localparam int OUT_BITS = VAL_W + ST_W + CUR_W;
    localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_POP_AT = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BEYOND = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch incoming word
        logic pick;      // choose target stack
        logic access;    // fill update and memory access
        logic take_rd;   // capture memory read data
        logic load_out;  // move result into output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic finished;  // command settled during pick
        logic need_rd;   // memory read in flight
        logic out_busy;  // output register holds an untaken word
    } dp_sts_t;

endpackage

// ----- src/set_of_stacks.sv -----
// ----------------------------------------------------------------------------
// set_of_stacks
// Row of fixed-depth stacks used as one larger stack, with push, pop and
// pop from a named stack.
// ----------------------------------------------------------------------------
// Commands run one at a time. A command settles while the target stack is
// picked (all stacks full, pop with everything empty, pop-at beyond current,
// unused opcode). A push, or a pop that finds its stack empty at the access
// step, goes from access straight to the load; a pop that reads the entry
// memory also waits for the registered read. The sequencer steps are: accept,
// pick the target stack from the current fill count, fill update and memory
// access, the registered memory read on pops, and load the output register.
// The load waits while the output register holds a word the master side has
// not taken, which stalls the input too. A new command is accepted while the
// previous result still waits on the master side. Entry memory needs no
// clearing; only entries below a fill count are read.
// ----------------------------------------------------------------------------
module set_of_stacks (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // opcode[1:0], push_value[33:2], stack_index[36:34], zero fill above
    input  logic [sos_pkg::IN_TW-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pop_value[31:0], status[33:32], current_stack[36:34], zero fill above
    output logic [sos_pkg::OUT_TW-1:0] m_tdata
);

    sos_pkg::dp_cmd_t cmd;
    sos_pkg::dp_sts_t sts;

    sos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sos_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ----- src/sos_ram.sv -----
// ----------------------------------------------------------------------------
// sos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sos_ctrl.sv -----
// ----------------------------------------------------------------------------
// sos_ctrl
// Sequencer: steps one command through pick, access, read and result load.
// ----------------------------------------------------------------------------
module sos_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             m_tready,
    input  sos_pkg::dp_sts_t sts,
    output sos_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_ACCESS,
        S_RDWAIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_PICK;
                end
            end
            S_PICK: begin
                cmd.pick   = 1'b1;
                state_next = sts.finished ? S_DONE : S_ACCESS;
            end
            S_ACCESS: begin
                cmd.access = 1'b1;
                state_next = sts.need_rd ? S_RDWAIT : S_DONE;
            end
            S_RDWAIT: begin
                cmd.take_rd = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!sts.out_busy || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- src/sos_dp.sv -----
// ----------------------------------------------------------------------------
// sos_dp
// Datapath: fill counts, current index, entry memory and result register.
// ----------------------------------------------------------------------------
module sos_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [sos_pkg::IN_TW-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sos_pkg::OUT_TW-1:0]  m_tdata,
    input  sos_pkg::dp_cmd_t            cmd,
    output sos_pkg::dp_sts_t            sts
);

    localparam int STK_W  = sos_pkg::STK_W;
    localparam int FILL_W = sos_pkg::FILL_W;
    localparam int ADDR_W = sos_pkg::ADDR_W;
    localparam int VAL_W  = sos_pkg::VAL_W;

    logic [sos_pkg::OP_W-1:0]  op_reg;
    logic [VAL_W-1:0]          pv_reg;
    logic [sos_pkg::IDX_W-1:0] idx_reg;
    logic [STK_W-1:0]          cur_reg;
    logic [STK_W-1:0]          cur_next;
    logic [STK_W-1:0]          tgt_reg;
    logic [STK_W-1:0]          tgt_next;
    logic [FILL_W-1:0]         fill_reg [sos_pkg::NUM_STACKS];
    logic [sos_pkg::ST_W-1:0]  st_reg;
    logic [sos_pkg::ST_W-1:0]  st_next;
    logic [VAL_W-1:0]          val_reg;

    logic [VAL_W-1:0]          out_val_reg;
    logic [sos_pkg::ST_W-1:0]  out_st_reg;
    logic [sos_pkg::CUR_W-1:0] out_cur_reg;
    logic                      out_valid_reg;

    // one fill-count read per cycle: current stack in pick, target in access
    logic [STK_W-1:0]  fsel;
    logic [FILL_W-1:0] fill_rd;
    logic              fin_next;
    logic              beyond;
    logic [ADDR_W-1:0] base;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    assign fsel    = cmd.pick ? cur_reg : tgt_reg;
    assign fill_rd = fill_reg[fsel];
    assign beyond  = 32'(idx_reg) > 32'(cur_reg);
    assign base    = ADDR_W'(tgt_reg) * ADDR_W'(sos_pkg::STACK_DEPTH);

    // pick the target stack
    always_comb begin
        cur_next = cur_reg;
        tgt_next = cur_reg;
        st_next  = sos_pkg::ST_OK;
        fin_next = 1'b0;
        unique case (op_reg)
            sos_pkg::OP_PUSH: begin
                if (fill_rd == FILL_W'(sos_pkg::STACK_DEPTH)) begin
                    if (cur_reg == STK_W'(sos_pkg::NUM_STACKS - 1)) begin
                        st_next  = sos_pkg::ST_FULL;
                        fin_next = 1'b1;
                    end else begin
                        cur_next = cur_reg + STK_W'(1);
                        tgt_next = cur_reg + STK_W'(1);
                    end
                end
            end
            sos_pkg::OP_POP: begin
                if (fill_rd == '0) begin
                    if (cur_reg == '0) begin
                        st_next  = sos_pkg::ST_EMPTY;
                        fin_next = 1'b1;
                    end else begin
                        cur_next = cur_reg - STK_W'(1);
                        tgt_next = cur_reg - STK_W'(1);
                    end
                end
            end
            sos_pkg::OP_POP_AT: begin
                if (beyond) begin
                    st_next  = sos_pkg::ST_BEYOND;
                    fin_next = 1'b1;
                end else begin
                    tgt_next = STK_W'(idx_reg);
                end
            end
            default: fin_next = 1'b1;
        endcase
    end

    assign ram_we    = cmd.access && (op_reg == sos_pkg::OP_PUSH);
    assign ram_waddr = base + ADDR_W'(fill_rd);
    assign ram_raddr = base + ADDR_W'(fill_rd) - ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sos_pkg::NUM_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (cmd.capture) begin
                op_reg  <= s_tdata[1:0];
                pv_reg  <= s_tdata[33:2];
                idx_reg <= s_tdata[36:34];
                st_reg  <= sos_pkg::ST_OK;
                val_reg <= '0;
            end
            if (cmd.pick) begin
                cur_reg <= cur_next;
                tgt_reg <= tgt_next;
                st_reg  <= st_next;
            end
            if (cmd.access) begin
                if (op_reg == sos_pkg::OP_PUSH) begin
                    fill_reg[tgt_reg] <= fill_rd + FILL_W'(1);
                end else if (fill_rd == '0) begin
                    st_reg <= sos_pkg::ST_EMPTY;
                end else begin
                    fill_reg[tgt_reg] <= fill_rd - FILL_W'(1);
                end
            end
            if (cmd.take_rd) begin
                val_reg <= ram_rdata;
            end
            if (cmd.load_out) begin
                out_val_reg   <= val_reg;
                out_st_reg    <= st_reg;
                out_cur_reg   <= sos_pkg::CUR_W'(cur_reg);
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    sos_ram #(
        .WIDTH (VAL_W),
        .DEPTH (sos_pkg::ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pv_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.finished = fin_next;
    assign sts.need_rd  = (op_reg != sos_pkg::OP_PUSH) && (fill_rd != '0);
    assign sts.out_busy = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(sos_pkg::OUT_TW - sos_pkg::OUT_BITS)'(0),
                       out_cur_reg, out_st_reg, out_val_reg};

endmodule

// ----- dv/set_of_stacks_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_of_stacks_tb
// Self-checking bench for the set-of-stacks block. A behavioral copy of the
// stack row predicts every result word. Directed tests cover the empty,
// full and beyond-current cases. Random command sequences fill the stacks,
// drain lower stacks and mix all commands. Random idling runs on both sides,
// with one long output stall.
// ----------------------------------------------------------------------------
module set_of_stacks_tb;
    import sos_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        status_t          status;
        logic [CUR_W-1:0] cur;
    } stack_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_TW-1:0] m_tdata;

    // predicted stack row
    logic [VAL_W-1:0] stack_words [NUM_STACKS][STACK_DEPTH];
    int               stack_count [NUM_STACKS];
    int               top_stack = 0;

    stack_result_t pending_results[$];
    int            op_count[4];
    int            status_count[4];
    int            results_seen = 0;
    int            mismatches   = 0;
    int            quiet_cycles = 0;
    int            src_idle_pct  = 0;
    int            sink_idle_pct = 0;
    int            hold_asked  = 0;
    int            hold_served = 0;

    set_of_stacks u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic stack_result_t apply_stack_cmd(opcode_t op, logic [VAL_W-1:0] word,
                                                      logic [IDX_W-1:0] idx);
        stack_result_t res;
        res.value  = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (stack_count[top_stack] == STACK_DEPTH && top_stack == NUM_STACKS - 1) begin
                    res.status = ST_FULL;
                end else begin
                    // advance to the next stack once the current one is full
                    if (stack_count[top_stack] == STACK_DEPTH)
                        top_stack++;
                    stack_words[top_stack][stack_count[top_stack]] = word;
                    stack_count[top_stack]++;
                end
            end
            OP_POP: begin
                // step back one stack when the current one is empty
                if (stack_count[top_stack] == 0 && top_stack != 0)
                    top_stack--;
                if (stack_count[top_stack] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    stack_count[top_stack]--;
                    res.value = stack_words[top_stack][stack_count[top_stack]];
                end
            end
            OP_POP_AT: begin
                if (idx > top_stack) begin
                    res.status = ST_BEYOND;
                end else if (stack_count[idx] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    stack_count[idx]--;
                    res.value = stack_words[idx][stack_count[idx]];
                end
            end
            default: ;
        endcase
        res.cur = CUR_W'(top_stack);
        op_count[op]++;
        status_count[res.status]++;
        return res;
    endfunction

    task automatic send_cmd(opcode_t op, logic [VAL_W-1:0] word, logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TW - IN_BITS){1'b0}}, idx, word, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(apply_stack_cmd(op, word, idx));
    endtask

    task automatic push_word(logic [VAL_W-1:0] word);
        send_cmd(OP_PUSH, word, IDX_W'($urandom));
    endtask

    task automatic pop_top();
        send_cmd(OP_POP, $urandom, IDX_W'($urandom));
    endtask

    task automatic pop_from(logic [IDX_W-1:0] idx);
        send_cmd(OP_POP_AT, $urandom, idx);
    endtask

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    task automatic test_empty_and_extremes();
        pop_top();
        pop_from(0);
        pop_from(7);
        pop_from(1);
        send_cmd(OP_NONE, $urandom, IDX_W'($urandom));
        push_word(32'h7fff_ffff);
        push_word(32'h8000_0000);
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        send_cmd(OP_NONE, $urandom, IDX_W'($urandom));
        pop_from(0);
        pop_from(1);
        repeat (3) pop_top();
        pop_top();
    endtask

    task automatic test_fill_to_overflow();
        while (!(top_stack == NUM_STACKS - 1 && stack_count[top_stack] == STACK_DEPTH))
            push_word($urandom);
        repeat (3) push_word($urandom);
        repeat (8) pop_from(IDX_W'($urandom_range(0, NUM_STACKS - 1)));
        while (top_stack != 0 || stack_count[0] != 0)
            pop_top();
        repeat (2) pop_top();
    endtask

    // Empty a lower stack by pop-at, then pop down so the step back lands on it.
    task automatic test_drained_lower_stack();
        int goal;
        int hole;
        repeat (4) begin
            goal = $urandom_range(1, 3);
            while (top_stack < goal)
                push_word($urandom);
            repeat ($urandom_range(1, 15)) push_word($urandom);
            hole = $urandom_range(0, top_stack - 1);
            while (stack_count[hole] != 0)
                pop_from(IDX_W'(hole));
            pop_from(IDX_W'(hole));
            while (top_stack > hole)
                pop_top();
            pop_top();
        end
    endtask

    task automatic test_random_mix(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                push_word($urandom);
            else if (pick < 72)
                pop_top();
            else if (pick < 90)
                pop_from(IDX_W'($urandom_range(0, top_stack)));
            else if (pick < 95)
                pop_from(IDX_W'($urandom));
            else
                send_cmd(OP_NONE, $urandom, IDX_W'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_asked++;
        test_random_mix(40);
    endtask

    initial begin : sink
        int hold_len;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_asked) begin
                hold_served++;
                hold_len = 0;
                while (hold_len < HOLD_CYCLES) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                    hold_len++;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        stack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[VAL_W-1:0] !== want.value ||
                    m_tdata[VAL_W +: ST_W] !== want.status ||
                    m_tdata[VAL_W + ST_W +: CUR_W] !== want.cur)
                    flag_mismatch($sformatf(
                        "result %0d: expected value %h status %s stack %0d, got value %h status %0d stack %0d",
                        results_seen, want.value, want.status.name(), want.cur,
                        m_tdata[VAL_W-1:0], m_tdata[VAL_W +: ST_W],
                        m_tdata[VAL_W + ST_W +: CUR_W]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("set_of_stacks: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 16;
        sink_idle_pct = 53;
        test_empty_and_extremes();
        test_fill_to_overflow();

        src_idle_pct  = 53;
        sink_idle_pct = 16;
        test_drained_lower_stack();
        test_random_mix(150);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_backpressure();
        test_random_mix(150);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("summary: %0d commands (%0d push, %0d pop, %0d pop-at, %0d unused), %0d results",
                 op_count[OP_PUSH] + op_count[OP_POP] + op_count[OP_POP_AT] + op_count[OP_NONE],
                 op_count[OP_PUSH], op_count[OP_POP], op_count[OP_POP_AT], op_count[OP_NONE],
                 results_seen);
        $display("summary: %0d all-full, %0d empty, %0d beyond-current; one %0d-cycle output stall",
                 status_count[ST_FULL], status_count[ST_EMPTY], status_count[ST_BEYOND],
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("set_of_stacks: match");
        else
            $display("set_of_stacks: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
src/sos_pkg.sv
src/sos_ram.sv
src/sos_ctrl.sv
src/sos_dp.sv
src/set_of_stacks.sv
dv/set_of_stacks_tb.sv
